>>> hw/rtl/hcl_pkg.sv
`default_nettype none

package hcl_pkg;

  localparam int SYM_W   = 8;
  localparam int RAW_W   = 20;
  localparam int CODED_W = 21;

  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [RAW_W-1:0]   raw_t;
  typedef logic [CODED_W-1:0] coded_t;

endpackage

`default_nettype wire

>>> hw/rtl/huffman_coded_length.sv
// Bytes are taken at one per cycle while busy is low; a byte marked last raises busy.
// After the last byte the block makes K passes over its histogram, with K the
// number of distinct byte values (K = 0 counts as 1); each pass scans the histogram RAM once.
// The merge loop shares one min/second-min tracker, one pair adder and one cost accumulator across all passes.
// Results cannot be stalled: out_valid is a one-cycle strobe.
// After reset (rst_n synchronous, active low) busy stays high while the RAM clear zeroes every entry.
`default_nettype none

module huffman_coded_length #(
  parameter int MAX_LEN  = 65536,
  parameter int ALPHABET = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire hcl_pkg::sym_t   in_symbol,
  input  wire logic            in_last,
  output logic                 out_valid,
  output hcl_pkg::raw_t        out_raw_bits,
  output hcl_pkg::coded_t      out_coded_bits,
  output logic                 out_overflow
);

  import hcl_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_DRAIN    = 4'd2;
  localparam logic [3:0] ST_SCAN     = 4'd3;
  localparam logic [3:0] ST_SCAN_END = 4'd4;
  localparam logic [3:0] ST_DECIDE   = 4'd5;
  localparam logic [3:0] ST_WR1      = 4'd6;
  localparam logic [3:0] ST_WR2      = 4'd7;
  localparam logic [3:0] ST_DONE     = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;

  // histogram RAM
  logic [LW-1:0] hist_mem [ALPHABET];
  logic [LW-1:0] rd_data_r;
  logic [AW-1:0] mem_ra;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [LW-1:0] mem_wd;

  // count pipeline
  logic          s_vld_r;
  logic [AW-1:0] s_sym_r;
  logic          fw_vld_r;
  logic [AW-1:0] fw_addr_r;
  logic [LW-1:0] fw_val_r;
  logic [LW-1:0] cnt_new;

  // scan / merge
  logic          rv_r;
  logic [AW-1:0] ridx_r;
  logic          have1_r, have1_nxt, have2_r, have2_nxt;
  logic [LW-1:0] m1_r, m1_nxt, m2_r, m2_nxt;
  logic [AW-1:0] i1_r, i1_nxt, i2_r, i2_nxt;
  logic [LW-1:0] sum_r;
  coded_t        cost_r;
  logic          merged_r;

  logic          accept;
  logic          counted;
  logic          last_idx;

  logic [LW+CODED_W-1:0] sum_wide;
  logic [LW+CODED_W-1:0] len_wide;
  logic [LW+3+RAW_W-1:0] raw_wide;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign counted  = ({1'b0, in_symbol} < (SYM_W+1)'(ALPHABET)) && (len_r != LW'(MAX_LEN));
  assign last_idx = (idx_r == AW'(ALPHABET - 1));

  assign sum_wide = {{CODED_W{1'b0}}, sum_r};
  assign len_wide = {{CODED_W{1'b0}}, len_r};
  assign raw_wide = {{RAW_W{1'b0}}, len_r, 3'b000};

  assign cnt_new = ((fw_vld_r && (fw_addr_r == s_sym_r)) ? fw_val_r : rd_data_r) + LW'(1);

  assign mem_ra = (state_r == ST_SCAN) ? idx_r : in_symbol[AW-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_r;
    mem_wd = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE, ST_DRAIN: begin
        mem_we = s_vld_r;
        mem_wa = s_sym_r;
        mem_wd = cnt_new;
      end
      ST_WR1: begin
        mem_we = 1'b1;
        mem_wa = i1_r;
        mem_wd = sum_r;
      end
      ST_WR2: begin
        mem_we = 1'b1;
        mem_wa = i2_r;
      end
      ST_DONE: begin
        mem_we = have1_r;
        mem_wa = i1_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= hist_mem[mem_ra];
  end

  // running min and second min over live (nonzero) entries
  always_comb begin
    have1_nxt = have1_r;
    have2_nxt = have2_r;
    m1_nxt    = m1_r;
    m2_nxt    = m2_r;
    i1_nxt    = i1_r;
    i2_nxt    = i2_r;
    if (state_r == ST_DRAIN || state_r == ST_WR2) begin
      have1_nxt = 1'b0;
      have2_nxt = 1'b0;
    end else if (rv_r && (rd_data_r != '0)) begin
      if (!have1_r || (rd_data_r < m1_r)) begin
        m2_nxt    = m1_r;
        i2_nxt    = i1_r;
        have2_nxt = have1_r;
        m1_nxt    = rd_data_r;
        i1_nxt    = ridx_r;
        have1_nxt = 1'b1;
      end else if (!have2_r || (rd_data_r < m2_r)) begin
        m2_nxt    = rd_data_r;
        i2_nxt    = ridx_r;
        have2_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_CLEAR: begin
        idx_nxt = idx_r + AW'(1);
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (counted) begin
            len_nxt = len_r + LW'(1);
          end else if ({1'b0, in_symbol} < (SYM_W+1)'(ALPHABET)) begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        idx_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        idx_nxt = idx_r + AW'(1);
        if (last_idx) begin
          idx_nxt   = '0;
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = have2_r ? ST_WR1 : ST_DONE;
      end
      ST_WR1: begin
        state_nxt = ST_WR2;
      end
      ST_WR2: begin
        idx_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_DONE: begin
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      idx_r     <= '0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      s_vld_r   <= 1'b0;
      fw_vld_r  <= 1'b0;
      rv_r      <= 1'b0;
      have1_r   <= 1'b0;
      have2_r   <= 1'b0;
      cost_r    <= '0;
      merged_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      s_vld_r   <= accept && counted;
      fw_vld_r  <= s_vld_r;
      rv_r      <= (state_r == ST_SCAN);
      have1_r   <= have1_nxt;
      have2_r   <= have2_nxt;
      out_valid <= (state_r == ST_DONE);
      if (state_r == ST_WR1) begin
        cost_r   <= cost_r + sum_wide[CODED_W-1:0];
        merged_r <= 1'b1;
      end else if (state_r == ST_DONE) begin
        cost_r   <= '0;
        merged_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_sym_r   <= in_symbol[AW-1:0];
    fw_addr_r <= s_sym_r;
    fw_val_r  <= cnt_new;
    ridx_r    <= idx_r;
    m1_r      <= m1_nxt;
    m2_r      <= m2_nxt;
    i1_r      <= i1_nxt;
    i2_r      <= i2_nxt;
    if (state_r == ST_DECIDE) begin
      sum_r <= m1_r + m2_r;
    end
    if (state_r == ST_DONE) begin
      out_raw_bits   <= raw_wide[RAW_W-1:0];
      out_coded_bits <= merged_r ? cost_r : len_wide[CODED_W-1:0];
      out_overflow   <= ovf_r;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hcl_pkg::*;

  localparam int MAX_LEN        = 65536;
  localparam int ALPHABET       = 256;
  localparam int RANDOM_BYTES   = 1620;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    raw_t   raw_bits;
    coded_t coded_bits;
    logic   overflow;
  } size_rec_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   start     = 1'b0;
  sym_t   in_symbol = '0;
  logic   in_last   = 1'b0;
  logic   busy;
  logic   out_valid;
  raw_t   out_raw_bits;
  coded_t out_coded_bits;
  logic   out_overflow;

  int unsigned byte_count [ALPHABET];
  int unsigned msg_len;
  bit          msg_dropped;
  size_rec_t   expected_sizes [$];

  int errors       = 0;
  int msgs_checked = 0;
  int bytes_sent   = 0;
  int idle_cycles  = 0;

  huffman_coded_length #(
    .MAX_LEN  (MAX_LEN),
    .ALPHABET (ALPHABET)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_symbol      (in_symbol),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_raw_bits   (out_raw_bits),
    .out_coded_bits (out_coded_bits),
    .out_overflow   (out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_counts();
    foreach (byte_count[i]) byte_count[i] = 0;
    msg_len     = 0;
    msg_dropped = 1'b0;
  endfunction

  // Sum of all merged weights = weighted leaf depth of the Huffman tree; a single distinct byte costs one bit per byte.
  function automatic longint unsigned huffman_cost();
    longint unsigned w [ALPHABET];
    longint unsigned cost;
    longint unsigned merged;
    int k;
    int a;
    int b;
    int i;
    k    = 0;
    cost = 0;
    for (i = 0; i < ALPHABET; i++) begin
      if (byte_count[i] != 0) begin
        w[k] = byte_count[i];
        k++;
      end
    end
    if (k == 0) return 0;
    if (k == 1) return msg_len;
    while (k > 1) begin
      a = 0;
      for (i = 1; i < k; i++) if (w[i] < w[a]) a = i;
      b = (a == 0) ? 1 : 0;
      for (i = 0; i < k; i++) if (i != a && w[i] < w[b]) b = i;
      merged = w[a] + w[b];
      cost += merged;
      w[a] = merged;
      w[b] = w[k-1];
      k--;
    end
    return cost;
  endfunction

  function automatic void count_byte(sym_t sym, logic last);
    size_rec_t rec;
    if (int'(sym) < ALPHABET) begin
      if (msg_len >= MAX_LEN) msg_dropped = 1'b1;
      else begin
        byte_count[sym]++;
        msg_len++;
      end
    end
    if (last) begin
      rec.raw_bits   = raw_t'(msg_len * 8);
      rec.coded_bits = coded_t'(huffman_cost());
      rec.overflow   = msg_dropped;
      expected_sizes.push_back(rec);
      clear_counts();
    end
  endfunction

  function automatic int pick_gap(bit gappy);
    int r;
    r = $urandom_range(99);
    if (!gappy || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Called at a rising edge; returns at the edge that accepted the beat.
  task automatic send_beat(sym_t sym, logic last, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_symbol <= sym;
    in_last   <= last;
    do @(posedge clk); while (busy !== 1'b0);
    count_byte(sym, last);
    bytes_sent++;
  endtask

  task automatic send_message(int len, int kinds, bit gappy);
    sym_t palette [ALPHABET];
    int   idx;
    for (int i = 0; i < kinds; i++) palette[i] = sym_t'($urandom);
    for (int j = 0; j < len; j++) begin
      idx = $urandom_range($urandom_range(kinds - 1));
      send_beat(palette[idx], j == len - 1, pick_gap(gappy));
    end
  endtask

  task automatic test_directed();
    send_beat(8'h00, 1'b1, 0);
    send_beat(8'hFF, 1'b1, 1);
    repeat (3) send_beat(8'h55, 1'b0, 0);
    send_beat(8'h55, 1'b1, 2);
    send_beat(8'hAA, 1'b0, 0);
    send_beat(8'h55, 1'b1, 0);
    send_beat(8'h01, 1'b0, 0);
    repeat (2) send_beat(8'h02, 1'b0, 1);
    repeat (3) send_beat(8'h04, 1'b0, 0);
    send_beat(8'h04, 1'b1, 0);
    send_beat(8'h80, 1'b0, 0);
    send_beat(8'h7F, 1'b0, 3);
    send_beat(8'h80, 1'b1, 0);
  endtask

  task automatic test_full_alphabet();
    for (int i = 0; i < ALPHABET; i++) send_beat(sym_t'(i), i == ALPHABET - 1, pick_gap(1'b1));
  endtask

  task automatic test_random();
    int sent;
    int r;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(99);
      if (r < 70) begin
        r = $urandom_range(12, 1);
        send_message(r, $urandom_range(4, 1), $urandom_range(3) != 0);
      end else if (r < 95) begin
        r = $urandom_range(60, 10);
        send_message(r, $urandom_range(16, 1), $urandom_range(3) != 0);
      end else begin
        r = $urandom_range(250, 50);
        send_message(r, $urandom_range(64, 17), $urandom_range(3) != 0);
      end
      sent += r;
    end
  endtask

  always @(posedge clk) begin
    size_rec_t exp_rec;
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_sizes.size());
        $display("Regression FAIL");
        $finish;
      end else if (out_valid === 1'b1) begin
        if (expected_sizes.size() == 0) begin
          $display("%0t: unexpected result raw=%0d coded=%0d ovf=%0b", $time,
                   out_raw_bits, out_coded_bits, out_overflow);
          errors++;
        end else begin
          exp_rec = expected_sizes.pop_front();
          msgs_checked++;
          if (out_raw_bits !== exp_rec.raw_bits) begin
            $display("%0t: raw_bits expected %0d actual %0d", $time,
                     exp_rec.raw_bits, out_raw_bits);
            errors++;
          end
          if (out_coded_bits !== exp_rec.coded_bits) begin
            $display("%0t: coded_bits expected %0d actual %0d", $time,
                     exp_rec.coded_bits, out_coded_bits);
            errors++;
          end
          if (out_overflow !== exp_rec.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time,
                     exp_rec.overflow, out_overflow);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    clear_counts();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_alphabet();
    test_random();
    start <= 1'b0;
    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d beats, checked %0d messages: short, single-symbol,", bytes_sent,
             msgs_checked);
    $display("full alphabet and random skewed messages with random gaps.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
